[rtl/pvm_pkg.sv]
package pvm_pkg;

  // Field widths
  localparam int COORD_W   = 32;
  localparam int DIM_W     = 10;
  localparam int VADDR_W   = 20;
  localparam int VAL_W     = 8;
  localparam int DIMS_W    = 3 * DIM_W;
  localparam int LIN_W     = DIMS_W + 1;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Request types
  localparam logic REQ_WRITE    = 1'b0;
  localparam logic REQ_CLASSIFY = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Z     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_DIMS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY     = 3'd7;

  // Per-axis index result
  typedef struct packed {
    logic             ok;
    logic [DIM_W-1:0] idx;
  } axis_res_t;

  // Request fields carried down the pipeline
  typedef struct packed {
    logic               req_type;
    logic [VADDR_W-1:0] voxel_addr;
    logic [VAL_W-1:0]   voxel_value;
  } req_info_t;

endpackage

[rtl/pvm_axis.sv]
// One axis lane: offset, scale by reciprocal spacing, truncate, range check.
// Three register stages: magnitude, product, index result.
module pvm_axis #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic [pvm_pkg::COORD_W-1:0] point,
  input  logic [pvm_pkg::COORD_W-1:0] base,
  input  logic [pvm_pkg::COORD_W-1:0] inv,
  input  logic [pvm_pkg::DIM_W-1:0]   dim,
  output pvm_pkg::axis_res_t          res
);

  localparam int CW     = pvm_pkg::COORD_W;
  localparam int PROD_W = 2 * CW;
  localparam int SHIFT  = 2 * FRAC_BITS;
  localparam int DW     = pvm_pkg::DIM_W;

  logic [CW:0]       diff;
  logic [CW-1:0]     mag;
  logic              neg;
  logic [PROD_W-1:0] prod;
  logic              neg_p;
  logic              q_zero;
  logic              q_hi_zero;
  logic [DW-1:0]     q_idx;

  // exact signed difference, 33 bits
  assign diff = {point[CW-1], point} - {base[CW-1], base};

  // stage 1: sign and magnitude (magnitude always fits 32 bits)
  always_ff @(posedge clk) begin
    neg <= diff[CW];
    if (diff[CW]) begin
      mag <= CW'(-diff);
    end else begin
      mag <= diff[CW-1:0];
    end
  end

  // stage 2: 32x32 product
  always_ff @(posedge clk) begin
    prod  <= mag * inv;
    neg_p <= neg;
  end

  // stage 3: truncate and range check
  assign q_zero    = ~|prod[PROD_W-1:SHIFT];
  assign q_hi_zero = ~|prod[PROD_W-1:SHIFT+DW];
  assign q_idx     = prod[SHIFT+DW-1:SHIFT];

  always_ff @(posedge clk) begin
    res.ok  <= q_hi_zero && (q_idx < dim) && (!neg_p || q_zero);
    res.idx <= q_idx;
  end

endmodule

[rtl/pvm_mask_mem.sv]
// Single-port byte mask memory, registered read data.
module pvm_mask_mem #(
  parameter int DEPTH  = 1048576,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         addr,
  input  logic [pvm_pkg::VAL_W-1:0] wdata,
  output logic [pvm_pkg::VAL_W-1:0] rdata
);

  logic [pvm_pkg::VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[rtl/pvm_result_fifo.sv]
// Small queue of keep flags between the pipeline and the output channel.
module pvm_result_fifo (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic push_keep,
  input  logic pop,
  output logic out_valid,
  output logic keep
);

  localparam int PW = pvm_pkg::FIFO_PTR_W;
  localparam int CW = pvm_pkg::FIFO_CNT_W;

  logic          entries [pvm_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_keep;
    end
  end

  assign out_valid = (count != '0);
  assign keep      = entries[rd_ptr];

endmodule

[rtl/point_voxel_mask_classifier_core.sv]
// Point-in-voxel-mask classifier.
// Input channel (in_valid/in_ready) takes one request per ready cycle. A write
// request (req_type 0) stores voxel_value at voxel_addr in the mask memory
// and yields no result. A classify request (req_type 1) carries a Q16.16
// point and yields one keep flag on the output channel (out_valid/out_ready).
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_wdata
// while no request is in flight.
// Throughput: one request per cycle while in_ready is high, set by the
// single mask memory port, which takes one access per cycle in request
// order.
// Up to 8 requests may be in flight; when the receiver stalls, results
// collect in an 8-entry queue and in_ready drops once the queue plus the
// pipeline hold 8 requests, so no result is ever lost.
// Reset clears the control state and loads register defaults (bases 0,
// spacings 1.0, grid 0, empty 0). The mask memory is not cleared; voxels
// must be written before they are classified against.
module point_voxel_mask_classifier_core #(
  parameter int MASK_DEPTH = 1048576,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [pvm_pkg::VADDR_W-1:0]   voxel_addr,
  input  logic [pvm_pkg::VAL_W-1:0]     voxel_value,
  input  logic [pvm_pkg::COORD_W-1:0]   point_x,
  input  logic [pvm_pkg::COORD_W-1:0]   point_y,
  input  logic [pvm_pkg::COORD_W-1:0]   point_z,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          keep,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [pvm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pvm_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int CW     = pvm_pkg::COORD_W;
  localparam int DW     = pvm_pkg::DIM_W;
  localparam int LW     = pvm_pkg::LIN_W;
  localparam int MEM_AW = $clog2(MASK_DEPTH);
  localparam int CNT_W  = pvm_pkg::FIFO_CNT_W;

  // configuration registers
  logic [CW-1:0]               base_x, base_y, base_z;
  logic [CW-1:0]               inv_x, inv_y, inv_z;
  logic [pvm_pkg::DIMS_W-1:0]  grid_dims;
  logic [2*DW-1:0]             dxdy;
  logic [pvm_pkg::VAL_W-1:0]   empty_value;
  logic [DW-1:0]               dx, dy, dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_x      <= '0;
      base_y      <= '0;
      base_z      <= '0;
      inv_x       <= CW'(64'd1 << FRAC_BITS);
      inv_y       <= CW'(64'd1 << FRAC_BITS);
      inv_z       <= CW'(64'd1 << FRAC_BITS);
      grid_dims   <= '0;
      dxdy        <= '0;
      empty_value <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pvm_pkg::CFG_BASE_X: base_x <= cfg_wdata;
        pvm_pkg::CFG_BASE_Y: base_y <= cfg_wdata;
        pvm_pkg::CFG_BASE_Z: base_z <= cfg_wdata;
        pvm_pkg::CFG_INV_X:  inv_x  <= cfg_wdata;
        pvm_pkg::CFG_INV_Y:  inv_y  <= cfg_wdata;
        pvm_pkg::CFG_INV_Z:  inv_z  <= cfg_wdata;
        pvm_pkg::CFG_GRID_DIMS: begin
          grid_dims <= cfg_wdata[pvm_pkg::DIMS_W-1:0];
          // slice size precomputed so each address term needs one multiply
          dxdy      <= cfg_wdata[DW-1:0] * cfg_wdata[2*DW-1:DW];
        end
        pvm_pkg::CFG_EMPTY:  empty_value <= cfg_wdata[pvm_pkg::VAL_W-1:0];
        default: ;
      endcase
    end
  end

  assign dx = grid_dims[DW-1:0];
  assign dy = grid_dims[2*DW-1:DW];
  assign dz = grid_dims[3*DW-1:2*DW];

  // handshakes and in-flight count
  logic             accept;
  logic             pop;
  logic [CNT_W-1:0] inflight;
  logic             leave_wr;

  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;
  assign in_ready = (inflight < CNT_W'(pvm_pkg::FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CNT_W'(accept) - CNT_W'(leave_wr) - CNT_W'(pop);
    end
  end

  // axis lanes (stages a, b, c)
  pvm_pkg::axis_res_t res_x, res_y, res_z;

  pvm_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
    .clk(clk), .point(point_x), .base(base_x), .inv(inv_x), .dim(dx), .res(res_x)
  );
  pvm_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
    .clk(clk), .point(point_y), .base(base_y), .inv(inv_y), .dim(dy), .res(res_y)
  );
  pvm_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_z (
    .clk(clk), .point(point_z), .base(base_z), .inv(inv_z), .dim(dz), .res(res_z)
  );

  // request info alongside the lanes
  pvm_pkg::req_info_t in_info;
  pvm_pkg::req_info_t a_info, b_info, c_info, d_info;
  logic               a_vld, b_vld, c_vld, d_vld, e_vld;

  assign in_info = '{req_type: req_type, voxel_addr: voxel_addr,
                     voxel_value: voxel_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
    end else begin
      a_vld <= accept;
      b_vld <= a_vld;
      c_vld <= b_vld;
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_info <= in_info;
    b_info <= a_info;
    c_info <= b_info;
    d_info <= c_info;
  end

  // stage d: linear address terms
  logic [DW-1:0]   d_i;
  logic [2*DW-1:0] d_jdx;
  logic [3*DW-1:0] d_kdd;
  logic            d_ok;

  always_ff @(posedge clk) begin
    d_i   <= res_x.idx;
    d_jdx <= res_y.idx * dx;
    d_kdd <= res_z.idx * dxdy;
    d_ok  <= res_x.ok && res_y.ok && res_z.ok;
  end

  // mask access: one per cycle, in request order, so a read after a write
  // to the same voxel sees the new byte without forwarding
  logic [LW-1:0]             lin_addr;
  logic                      rd_in_range;
  logic                      wr_in_range;
  logic                      is_rd;
  logic                      mem_en;
  logic [MEM_AW-1:0]         mem_addr;
  logic [pvm_pkg::VAL_W-1:0] mem_rdata;

  assign lin_addr    = LW'(d_i) + LW'(d_jdx) + LW'(d_kdd);
  assign rd_in_range = 32'(lin_addr) < 32'(MASK_DEPTH);
  assign wr_in_range = 32'(d_info.voxel_addr) < 32'(MASK_DEPTH);
  assign leave_wr    = d_vld && (d_info.req_type == pvm_pkg::REQ_WRITE);
  assign is_rd       = d_vld && (d_info.req_type == pvm_pkg::REQ_CLASSIFY);
  assign mem_en      = (leave_wr && wr_in_range) || (is_rd && d_ok && rd_in_range);
  assign mem_addr    = leave_wr ? MEM_AW'(d_info.voxel_addr) : MEM_AW'(lin_addr);

  pvm_mask_mem #(.DEPTH(MASK_DEPTH), .ADDR_W(MEM_AW)) u_mask_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (leave_wr),
    .addr  (mem_addr),
    .wdata (d_info.voxel_value),
    .rdata (mem_rdata)
  );

  // stage e: read data back, form the flag
  logic e_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= is_rd;
    end
  end

  always_ff @(posedge clk) begin
    e_hit <= d_ok && rd_in_range;
  end

  pvm_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (e_vld),
    .push_keep (e_hit && (mem_rdata != empty_value)),
    .pop       (pop),
    .out_valid (out_valid),
    .keep      (keep)
  );

endmodule

[tb/tb_point_voxel_mask_classifier_core.sv]
module tb_point_voxel_mask_classifier_core;

  localparam int MASK_DEPTH    = 1048576;
  localparam int FRAC_BITS     = 16;
  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam int SETTLE_CYCLES = 10;
  localparam int DRAIN_CYCLES  = 20;
  localparam int SINK_HOLD     = 200;
  localparam int STALL_LIMIT   = 2000;

  // Shadow of the register file
  typedef struct packed {
    logic [31:0] base_x;
    logic [31:0] base_y;
    logic [31:0] base_z;
    logic [31:0] inv_x;
    logic [31:0] inv_y;
    logic [31:0] inv_z;
    logic [pvm_pkg::DIMS_W-1:0] dims;
    logic [pvm_pkg::VAL_W-1:0] empty_val;
  } grid_setting_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = pvm_pkg::REQ_WRITE;
  logic [pvm_pkg::VADDR_W-1:0] voxel_addr = '0;
  logic [pvm_pkg::VAL_W-1:0] voxel_value = '0;
  logic [pvm_pkg::COORD_W-1:0] point_x = '0;
  logic [pvm_pkg::COORD_W-1:0] point_y = '0;
  logic [pvm_pkg::COORD_W-1:0] point_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic keep;
  logic cfg_wr_en = 1'b0;
  logic [pvm_pkg::CFG_IDX_W-1:0] cfg_index = pvm_pkg::CFG_BASE_X;
  logic [pvm_pkg::CFG_W-1:0] cfg_wdata = '0;

  grid_setting_t regs_now;
  logic [pvm_pkg::VAL_W-1:0] voxel_shadow [int unsigned];
  logic keep_flags_due [$];
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  bit steady_flow = 1'b0;
  bit sink_hold_pending = 1'b0;

  always #6 clk = ~clk;

  point_voxel_mask_classifier_core #(
    .MASK_DEPTH(MASK_DEPTH),
    .FRAC_BITS (FRAC_BITS)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .voxel_addr (voxel_addr),
    .voxel_value(voxel_value),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .keep       (keep),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Voxel lookup predictor
  // ---------------------------------------------------------------------------

  // One axis: exact (coord - base) * inv, truncated toward zero
  function automatic bit axis_cell(input logic [31:0] coord, base, inv,
                                   input logic [pvm_pkg::DIM_W-1:0] dim,
                                   output longint unsigned cell_idx);
    logic [63:0] diff, mag, scaled;
    diff = {{32{coord[31]}}, coord} - {{32{base[31]}}, base};
    mag = diff[63] ? -diff : diff;
    scaled = (mag * {32'b0, inv}) >> (2 * FRAC_BITS);
    cell_idx = scaled;
    if (diff[63] && scaled != 0) return 1'b0;
    return scaled < {54'b0, dim};
  endfunction

  // True when the point falls on a voxel that lives in the mask
  function automatic bit locate_voxel(input logic [31:0] px, py, pz,
                                      output longint unsigned lin);
    longint unsigned i, j, k, dx, dy;
    bit in_grid;
    dx = regs_now.dims[pvm_pkg::DIM_W-1:0];
    dy = regs_now.dims[2*pvm_pkg::DIM_W-1:pvm_pkg::DIM_W];
    lin = 0;
    in_grid = axis_cell(px, regs_now.base_x, regs_now.inv_x,
                        regs_now.dims[pvm_pkg::DIM_W-1:0], i)
           && axis_cell(py, regs_now.base_y, regs_now.inv_y,
                        regs_now.dims[2*pvm_pkg::DIM_W-1:pvm_pkg::DIM_W], j)
           && axis_cell(pz, regs_now.base_z, regs_now.inv_z,
                        regs_now.dims[3*pvm_pkg::DIM_W-1:2*pvm_pkg::DIM_W], k);
    if (in_grid) lin = i + j * dx + k * dx * dy;
    return in_grid && lin < MASK_DEPTH;
  endfunction

  function automatic logic predict_keep(input logic [31:0] px, py, pz);
    longint unsigned lin;
    if (!locate_voxel(px, py, pz, lin)) return 1'b0;
    return voxel_shadow[lin[pvm_pkg::VADDR_W-1:0]] != regs_now.empty_val;
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------

  // Mostly short, sometimes medium, rarely long
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [pvm_pkg::VAL_W-1:0] voxel_byte();
    if ($urandom_range(0, 9) < 3) return regs_now.empty_val;
    return pvm_pkg::VAL_W'($urandom);
  endfunction

  function automatic int pick_index(input logic [pvm_pkg::DIM_W-1:0] dim);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return (dim == 0) ? 0 : $urandom_range(0, int'(dim) - 1);
    if (r < 88) return -1;
    if (r < 95) return int'(dim);
    return $urandom_range(0, 1100);
  endfunction

  // Coordinate that lands near the given cell index on one axis
  function automatic logic [31:0] coord_near(input logic [31:0] base, inv, input int idx);
    longint num, d;
    if (inv == 0) return $urandom;
    num = (longint'(idx) <<< 32) + longint'({32'b0, 32'($urandom)});
    d = num / longint'({32'b0, inv});
    return base + d[31:0];
  endfunction

  function automatic logic [31:0] random_base();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    if (r == 6) return 32'h8000_0000;
    if (r == 7) return 32'h7FFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [31:0] random_inv();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(32'h0000_4000, 32'h0004_0000);
    if (r == 6) return 32'h0;
    if (r == 7) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [pvm_pkg::DIM_W-1:0] random_dim();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 14) return pvm_pkg::DIM_W'($urandom_range(1, 12));
    if (r == 14) return 0;
    if (r < 17) return 10'd1023;
    return pvm_pkg::DIM_W'($urandom_range(1, 1023));
  endfunction

  function automatic grid_setting_t make_setting(input logic [31:0] bx, by, bz, ix, iy, iz,
                                                 input logic [pvm_pkg::DIMS_W-1:0] dims,
                                                 input logic [pvm_pkg::VAL_W-1:0] empty_val);
    grid_setting_t s;
    s.base_x = bx;
    s.base_y = by;
    s.base_z = bz;
    s.inv_x = ix;
    s.inv_y = iy;
    s.inv_z = iz;
    s.dims = dims;
    s.empty_val = empty_val;
    return s;
  endfunction

  function automatic grid_setting_t random_setting();
    int unsigned r;
    logic [pvm_pkg::VAL_W-1:0] ev;
    r = $urandom_range(0, 9);
    ev = (r < 4) ? 8'h00 : (r < 6) ? 8'hFF : 8'($urandom);
    return make_setting(random_base(), random_base(), random_base(),
                        random_inv(), random_inv(), random_inv(),
                        {random_dim(), random_dim(), random_dim()}, ev);
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offer one request, hold it until taken, then record what it implies
  task automatic send_request(input logic rtype, input logic [pvm_pkg::VADDR_W-1:0] addr,
                              input logic [pvm_pkg::VAL_W-1:0] value,
                              input logic [31:0] px, py, pz);
    int unsigned gap;
    gap = (steady_flow || $urandom_range(0, 1) == 0) ? 0 : idle_length();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rtype;
    voxel_addr <= addr;
    voxel_value <= value;
    point_x <= px;
    point_y <= py;
    point_z <= pz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (rtype == pvm_pkg::REQ_WRITE) voxel_shadow[addr] = value;
    else keep_flags_due.push_back(predict_keep(px, py, pz));
  endtask

  task automatic write_voxel(input logic [pvm_pkg::VADDR_W-1:0] addr,
                             input logic [pvm_pkg::VAL_W-1:0] value);
    send_request(pvm_pkg::REQ_WRITE, addr, value, $urandom, $urandom, $urandom);
  endtask

  // A voxel the point would read gets written first if it never was
  task automatic classify_point(input logic [31:0] px, py, pz);
    longint unsigned lin;
    if (locate_voxel(px, py, pz, lin) && !voxel_shadow.exists(lin[pvm_pkg::VADDR_W-1:0]))
      write_voxel(lin[pvm_pkg::VADDR_W-1:0], voxel_byte());
    send_request(pvm_pkg::REQ_CLASSIFY, pvm_pkg::VADDR_W'($urandom),
                 pvm_pkg::VAL_W'($urandom), px, py, pz);
  endtask

  // Drop valid, let every result come back, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (keep_flags_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pvm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pvm_pkg::CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic program_registers(input grid_setting_t s);
    write_reg(pvm_pkg::CFG_BASE_X, s.base_x);
    write_reg(pvm_pkg::CFG_BASE_Y, s.base_y);
    write_reg(pvm_pkg::CFG_BASE_Z, s.base_z);
    write_reg(pvm_pkg::CFG_INV_X, s.inv_x);
    write_reg(pvm_pkg::CFG_INV_Y, s.inv_y);
    write_reg(pvm_pkg::CFG_INV_Z, s.inv_z);
    write_reg(pvm_pkg::CFG_GRID_DIMS,
              {{(pvm_pkg::CFG_W-pvm_pkg::DIMS_W){1'b0}}, s.dims});
    write_reg(pvm_pkg::CFG_EMPTY,
              {{(pvm_pkg::CFG_W-pvm_pkg::VAL_W){1'b0}}, s.empty_val});
    cfg_wr_en <= 1'b0;
    regs_now = s;
  endtask

  // Mix of mask writes and points, most of them aimed at the grid
  task automatic random_traffic(input int count);
    longint unsigned lin;
    logic [31:0] px, py, pz;
    repeat (count) begin
      if ($urandom_range(0, 99) < 85) begin
        px = coord_near(regs_now.base_x, regs_now.inv_x,
                        pick_index(regs_now.dims[pvm_pkg::DIM_W-1:0]));
        py = coord_near(regs_now.base_y, regs_now.inv_y,
                        pick_index(regs_now.dims[2*pvm_pkg::DIM_W-1:pvm_pkg::DIM_W]));
        pz = coord_near(regs_now.base_z, regs_now.inv_z,
                        pick_index(regs_now.dims[3*pvm_pkg::DIM_W-1:2*pvm_pkg::DIM_W]));
      end else begin
        px = $urandom;
        py = $urandom;
        pz = $urandom;
      end
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1) == 0 && locate_voxel(px, py, pz, lin))
          write_voxel(lin[pvm_pkg::VADDR_W-1:0], voxel_byte());
        else
          write_voxel(pvm_pkg::VADDR_W'($urandom), pvm_pkg::VAL_W'($urandom));
      end else begin
        classify_point(px, py, pz);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: empty grid, nothing can be kept
  task automatic test_zero_grid();
    write_voxel('0, 8'h00);
    write_voxel({pvm_pkg::VADDR_W{1'b1}}, 8'hFF);
    classify_point(32'h0, 32'h0, 32'h0);
    classify_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
    wait_idle();
  endtask

  // 4x4x4 grid at unit spacing: corners, edges and the empty value
  task automatic test_small_grid();
    program_registers(make_setting(32'h0, 32'h0, 32'h0, ONE, ONE, ONE,
                                   {10'd4, 10'd4, 10'd4}, 8'h00));
    write_voxel(20'd0, 8'h5A);
    write_voxel(20'd63, 8'hFF);
    write_voxel(20'd1, 8'h00);
    classify_point(32'h0, 32'h0, 32'h0);
    classify_point(32'h0003_FFFF, 32'h0003_FFFF, 32'h0003_FFFF);
    classify_point(32'h0001_0000, 32'h0, 32'h0);
    // half a cell below the origin still maps to cell 0
    classify_point(32'hFFFF_8000, 32'h0, 32'h0);
    classify_point(32'h0, 32'h0, 32'hFFFF_FFFF);
    // a whole cell below is outside, as is one past the far edge
    classify_point(32'hFFFF_0000, 32'h0, 32'h0);
    classify_point(32'h0, 32'h0004_0000, 32'h0);
    classify_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    wait_idle();
  endtask

  // Extreme register values and a grid larger than the mask
  task automatic test_extreme_registers();
    program_registers(make_setting(32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                                   32'h0, 32'hFFFF_FFFF, ONE,
                                   {10'd1023, 10'd1023, 10'd1023}, 8'hFF));
    classify_point(32'h1234_5678, 32'h7FFF_FFFF, 32'h0001_0000);
    // linear address past the end of the mask reads as empty
    classify_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0002_0000);
    classify_point(32'h8000_0000, 32'h7FFF_FFFE, 32'h0);
    classify_point(32'h0, 32'h8000_0000, 32'h0);
    classify_point(32'h0, 32'h8000_FFFF, 32'h0);
    // voxel equal to the empty value
    write_voxel(20'd0, 8'hFF);
    classify_point(32'h0, 32'h7FFF_FFFF, 32'h0);
    wait_idle();
  endtask

  task automatic test_back_to_back();
    program_registers(make_setting(32'hFFFF_0000, 32'h0, 32'h0001_8000,
                                   32'h0000_8000, ONE, 32'h0002_0000,
                                   {10'd6, 10'd5, 10'd7}, 8'h00));
    steady_flow = 1'b1;
    random_traffic(100);
    steady_flow = 1'b0;
    wait_idle();
  endtask

  // Receiver stalls long enough for the block to fill and push back
  task automatic test_backpressure();
    program_registers(make_setting(32'h0, 32'h0, 32'h0, ONE, ONE, ONE,
                                   {10'd8, 10'd8, 10'd8}, 8'h00));
    @(negedge clk);
    sink_hold_pending = 1'b1;
    @(posedge clk);
    steady_flow = 1'b1;
    random_traffic(40);
    steady_flow = 1'b0;
    // sender waits for every result before going on
    wait_idle();
    random_traffic(30);
    wait_idle();
  endtask

  task automatic test_random_phases();
    repeat (5) begin
      program_registers(random_setting());
      random_traffic(110);
      wait_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Receiver ready with random stalls; a requested hold is counted here
  initial begin : result_sink
    int unsigned stall;
    forever begin
      @(posedge clk);
      if (sink_hold_pending) begin
        sink_hold_pending = 1'b0;
        stall = SINK_HOLD;
      end else if (!steady_flow && $urandom_range(0, 5) == 0) begin
        stall = idle_length();
      end else begin
        stall = 0;
      end
      out_ready <= (stall == 0);
      repeat (stall) @(posedge clk);
    end
  end

  always @(posedge clk) begin : keep_check
    logic want;
    if (!rst && out_valid && out_ready) begin
      if (keep_flags_due.size() == 0) begin
        $error("result with nothing pending: keep=%0b", keep);
        fail_count++;
      end else begin
        want = keep_flags_due.pop_front();
        if (keep !== want) begin
          $error("keep: expected %0b, actual %0b", want, keep);
          fail_count++;
        end
      end
    end
  end

  // No request or result moving for too long means the block hung
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : run_tests
    regs_now = make_setting(32'h0, 32'h0, 32'h0, ONE, ONE, ONE, '0, 8'h00);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_zero_grid();
    test_small_grid();
    test_extreme_registers();
    test_back_to_back();
    test_backpressure();
    test_random_phases();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/pvm_pkg.sv
rtl/pvm_axis.sv
rtl/pvm_mask_mem.sv
rtl/pvm_result_fifo.sv
rtl/point_voxel_mask_classifier_core.sv
tb/tb_point_voxel_mask_classifier_core.sv
